[hdl/wfba_pkg.sv]
// Shared constants, codes and types for the worst-fit block allocator.
`default_nettype none
package wfba_pkg;

   localparam int FUNC_W    = 2;
   localparam int IDX_W     = 6;
   localparam int AMT_W     = 32;
   localparam int STATUS_W  = 2;
   localparam int LEFT_W    = 32;
   localparam int TOTAL_W   = 38;
   localparam int CNT_W     = 7;

   localparam int MAX_BLOCKS_DEF = 64;
   localparam int SIZE_BITS_DEF  = 32;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_ALLOC  = 2'd1,
      FUNC_REPORT = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE   = 2'd0,
      STAT_NOFIT  = 2'd1,
      STAT_UNUSED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

endpackage
`default_nettype wire

[hdl/wfba_if.sv]
// Valid/ready channel interfaces for request, response and register write words.
`default_nettype none
interface wfba_req_if;
   logic                       valid;
   logic                       ready;
   logic [wfba_pkg::FUNC_W-1:0] func;
   logic [wfba_pkg::IDX_W-1:0]  block_index;
   logic [wfba_pkg::AMT_W-1:0]  amount;
   modport source (output valid, func, block_index, amount, input ready);
   modport sink   (input valid, func, block_index, amount, output ready);
endinterface

interface wfba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [wfba_pkg::STATUS_W-1:0] status;
   logic [wfba_pkg::IDX_W-1:0]    chosen_block;
   logic [wfba_pkg::LEFT_W-1:0]   block_left;
   logic [wfba_pkg::TOTAL_W-1:0]  total_left;
   modport source (output valid, status, chosen_block, block_left, total_left, input ready);
   modport sink   (input valid, status, chosen_block, block_left, total_left, output ready);
endinterface

interface wfba_csr_if;
   logic                       valid;
   logic                       ready;
   logic [wfba_pkg::CNT_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

[hdl/worst_fit_block_allocator.sv]
// Worst-fit block allocator: free-size table in one memory, scanned one block per cycle.
// Use:
//   req  - request word: func (load size, allocate, report), block_index, amount.
//          One word is worked on at a time; req.ready is high only when idle.
//   rsp  - one response word per request: status, chosen_block, block_left and
//          the running free total. A response register parts rsp from req, so a
//          waiting response never blocks the next request from being taken.
//   csr  - write word for block_count (blocks in use, counted from block 0);
//          always ready, to be written while the block is idle.
// Sequence:
//   Load, report and an unused code pass READ (read the entry) and FINISH
//   (update and register the response), then return to IDLE for the next
//   request. Allocate reads one entry a cycle in SCAN over used =
//   min(block_count, MAX_BLOCKS) entries, then goes through DRAIN and FINISH;
//   when used is 0 it goes straight from IDLE to FINISH.
// Reset:
//   Synchronous. After reset a clearing pass writes zero to every entry, one a
//   cycle, with req.ready low; csr writes are taken.
// Stall: if rsp.ready is low the finished word waits in the response register
//   and the block holds its result stage until that register frees up.
`default_nettype none
module worst_fit_block_allocator #(
   parameter int MAX_BLOCKS = wfba_pkg::MAX_BLOCKS_DEF,
   parameter int SIZE_BITS  = wfba_pkg::SIZE_BITS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   wfba_req_if.sink    req,
   wfba_rsp_if.source  rsp,
   wfba_csr_if.sink    csr
);
   import wfba_pkg::*;

   localparam int AW   = $clog2(MAX_BLOCKS);
   localparam int CW   = $clog2(MAX_BLOCKS + 1);
   localparam int UW   = (CW > CNT_W) ? CW : CNT_W;
   localparam int IW   = (CW > IDX_W) ? CW : IDX_W;
   localparam int CMPW = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

   // free-size table
   logic [SIZE_BITS-1:0] mem [MAX_BLOCKS];
   logic [SIZE_BITS-1:0] mem_q_ff;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [SIZE_BITS-1:0] mem_wdata;
   logic [AW-1:0]        mem_raddr;

   state_type            state_ff, state_in;
   logic [CW-1:0]        ptr_ff, ptr_in;
   func_type             func_ff, func_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [AMT_W-1:0]     amt_ff, amt_in;
   logic [CW-1:0]        used_ff, used_in;
   logic                 found_ff, found_in;
   logic [SIZE_BITS-1:0] best_ff, best_in;
   logic [AW-1:0]        pick_ff, pick_in;
   logic                 scan_vld_ff, scan_vld_in;
   logic [AW-1:0]        scan_idx_ff, scan_idx_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]     rsp_block_ff, rsp_block_in;
   logic [LEFT_W-1:0]    rsp_left_ff, rsp_left_in;

   logic                 req_take;
   logic                 out_free;
   logic [UW-1:0]        count_ext;
   logic [CW-1:0]        used_now;
   logic [CMPW-1:0]      f_x, a_x, diff;
   logic                 fits, take;
   logic                 idx_bad;
   logic [SIZE_BITS-1:0] load_val;

   // ---------------------------------------------------------------- memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= mem[mem_raddr];
   end

   // ---------------------------------------------------------- shared terms
   assign req.ready = (state_ff == ST_IDLE);
   assign csr.ready = 1'b1;
   assign req_take  = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   // blocks in use: block_count clipped to the table depth
   assign count_ext = UW'(count_ff);
   assign used_now  = (count_ext < UW'(MAX_BLOCKS)) ? CW'(count_ext) : CW'(MAX_BLOCKS);

   // one scan step: fit test and leftover of the entry read last cycle
   assign f_x  = CMPW'(mem_q_ff);
   assign a_x  = CMPW'(amt_ff);
   assign diff = f_x - a_x;
   assign fits = (a_x <= f_x);
   // ">=" lets a later block with an equal leftover win the tie
   assign take = scan_vld_ff && fits && (!found_ff || SIZE_BITS'(diff) >= best_ff);

   assign idx_bad  = (IW'(idx_ff) >= IW'(used_ff));
   assign load_val = SIZE_BITS'(amt_ff);

   // ------------------------------------------------------------ next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (ptr_ff == CW'(MAX_BLOCKS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               if (req.func == FUNC_ALLOC) begin
                  state_in = (used_now == '0) ? ST_FINISH : ST_SCAN;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_FINISH;
         end
         ST_SCAN: begin
            if (ptr_ff + 1'b1 == used_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------ outputs and data
   always_comb begin
      ptr_in        = ptr_ff;
      func_in       = func_ff;
      idx_in        = idx_ff;
      amt_in        = amt_ff;
      used_in       = used_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      pick_in       = pick_ff;
      scan_vld_in   = 1'b0;
      scan_idx_in   = ptr_ff[AW-1:0];
      total_in      = total_ff;
      count_in      = csr.valid ? csr.data : count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_block_in  = rsp_block_ff;
      rsp_left_in   = rsp_left_ff;
      mem_we        = 1'b0;
      mem_waddr     = ptr_ff[AW-1:0];
      mem_wdata     = '0;
      mem_raddr     = AW'(idx_ff);

      // fold each returned scan entry into the running best
      if (take) begin
         found_in = 1'b1;
         best_in  = SIZE_BITS'(diff);
         pick_in  = scan_idx_ff;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            ptr_in = ptr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_take) begin
               func_in  = func_type'(req.func);
               idx_in   = req.block_index;
               amt_in   = req.amount;
               used_in  = used_now;
               found_in = 1'b0;
               ptr_in   = '0;
            end
         end
         ST_READ: begin
            // entry addressed by idx, data lands in mem_q_ff
         end
         ST_SCAN: begin
            mem_raddr   = ptr_ff[AW-1:0];
            scan_vld_in = 1'b1;
            ptr_in      = ptr_ff + 1'b1;
         end
         ST_DRAIN: begin
            // last entry is compared this cycle
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               case (func_ff)
                  FUNC_ALLOC: begin
                     if (found_ff) begin
                        mem_we        = 1'b1;
                        mem_waddr     = pick_ff;
                        mem_wdata     = best_ff;
                        total_in      = total_ff - TOTAL_W'(amt_ff);
                        rsp_status_in = STAT_DONE;
                        rsp_block_in  = IDX_W'(pick_ff);
                        rsp_left_in   = LEFT_W'(best_ff);
                     end else begin
                        rsp_status_in = STAT_NOFIT;
                        rsp_block_in  = '0;
                        rsp_left_in   = '0;
                     end
                  end
                  FUNC_LOAD: begin
                     rsp_block_in = idx_ff;
                     if (idx_bad) begin
                        rsp_status_in = STAT_UNUSED;
                        rsp_left_in   = '0;
                     end else begin
                        mem_we        = 1'b1;
                        mem_waddr     = AW'(idx_ff);
                        mem_wdata     = load_val;
                        total_in      = total_ff - TOTAL_W'(mem_q_ff) + TOTAL_W'(load_val);
                        rsp_status_in = STAT_DONE;
                        rsp_left_in   = LEFT_W'(load_val);
                     end
                  end
                  FUNC_REPORT: begin
                     rsp_block_in = idx_ff;
                     if (idx_bad) begin
                        rsp_status_in = STAT_UNUSED;
                        rsp_left_in   = '0;
                     end else begin
                        rsp_status_in = STAT_DONE;
                        rsp_left_in   = LEFT_W'(mem_q_ff);
                     end
                  end
                  default: begin
                     // unused function code: no change
                     rsp_status_in = STAT_UNUSED;
                     rsp_block_in  = idx_ff;
                     rsp_left_in   = '0;
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         scan_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
         total_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         scan_vld_ff  <= scan_vld_in;
         found_ff     <= found_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      idx_ff        <= idx_in;
      amt_ff        <= amt_in;
      used_ff       <= used_in;
      best_ff       <= best_in;
      pick_ff       <= pick_in;
      scan_idx_ff   <= scan_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_left_ff   <= rsp_left_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.chosen_block = rsp_block_ff;
   assign rsp.block_left   = rsp_left_ff;
   assign rsp.total_left   = total_ff;

   // ------------------------------------------------------------ assertions
   // one word in flight: after a take the request side closes
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req.ready)
      else $error("request taken while another is in flight");

   // every scan read returns an entry to compare in the next cycle
   a_scan_return: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> scan_vld_ff)
      else $error("scan read lost");

   // table writes only from the clearing pass or the result stage
   a_write_stage: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR || state_ff == ST_FINISH))
      else $error("table written outside clear or finish");

   // a no-fit response names no block and no space
   a_nofit_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STAT_NOFIT) |->
         (rsp_block_ff == '0 && rsp_left_ff == '0))
      else $error("no-fit response carries block data");

endmodule
`default_nettype wire
